[src/credential_cache_ttl_evict_assert.svh]
// Assertion helpers for the credential cache.
// Both need clk in the using module; the first also needs arst_n.
`ifndef CREDENTIAL_CACHE_TTL_EVICT_ASSERT_SVH
`define CREDENTIAL_CACHE_TTL_EVICT_ASSERT_SVH

// checked only out of reset
`define CCTE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked on every edge, reset included
`define CCTE_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/ccte_pkg.sv]
`default_nettype none

package ccte_pkg;

	localparam int DIG_W  = 64;
	localparam int TIME_W = 32;
	localparam int SLOT_W = 7;

	localparam logic [TIME_W-1:0] DEFAULT_LIFETIME = 32'd86400;

	localparam logic KIND_LOOKUP = 1'b0;
	localparam logic KIND_CLEAR  = 1'b1;

	localparam logic [1:0] ST_HIT_VALID     = 2'd0;
	localparam logic [1:0] ST_HIT_EXPIRED   = 2'd1;
	localparam logic [1:0] ST_MISS_INSERTED = 2'd2;
	localparam logic [1:0] ST_CLEARED       = 2'd3;

	typedef struct packed {
		logic              kind;
		logic [DIG_W-1:0]  digest_high;
		logic [DIG_W-1:0]  digest_low;
		logic [TIME_W-1:0] now_seconds;
		logic [SLOT_W-1:0] clear_slot;
	} req_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [SLOT_W-1:0] slot_index;
	} rsp_t;

	// controller -> datapath
	typedef struct packed {
		logic load;      // capture the input word, restart the scan
		logic issue;     // read the slot at the scan index
		logic scan_rst;  // restart the scan for the earliest expiry
		logic track;     // follow the earliest expiry on read data
		logic wr_ins;    // write the new entry
		logic wr_clr;    // zero the selected slot
		logic res_hit;
		logic res_ins;
		logic res_clr;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic match;  // read data matches the digest
		logic more;   // slots left to read below the fill count
		logic pend;   // a read is in flight
		logic full;
	} sts_t;

endpackage

`default_nettype wire

[src/credential_cache_ttl_evict.sv]
`default_nettype none

// Credential cache with per-entry expiry and earliest-expiry replacement.
// Command port: a word is taken on a clock edge with start high and busy low.
// kind selects a lookup (digest + now) or the invalidation of clear_slot.
// The result word (status, slot_index) is on rsp for one cycle with done high;
// the receiver must take it then, there is no way to hold it off.
// Steps from the accepting edge to done:
//   invalidate: the selected slot is zeroed as the result is given
//   hit: slots are read from slot 0 upward until the digest matches
//   miss, cache not full: the filled slots are read, then slot fill is written
//   miss, cache full: one read-port pass to look for the digest, a second pass
//   to find the earliest expiry, whose slot is then overwritten
// One item at a time; the next is taken in the cycle done is shown.
// The slot scans are set by the single read port of the entry memory, one slot
// per cycle with a registered read.
// cfg_we/cfg_wdata set the lifetime added to now on insert; write it idle only.
// Reset empties the cache (fill count zero) and sets the lifetime to 86400 s.
// No clearing pass runs: slots at or above the fill count are never read.
module credential_cache_ttl_evict #(
	parameter int SLOTS = 128
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output logic                              busy,
	input  wire ccte_pkg::req_t               req,
	input  wire logic                         cfg_we,
	input  wire logic [ccte_pkg::TIME_W-1:0]  cfg_wdata,
	output logic                              done,
	output ccte_pkg::rsp_t                    rsp
);

	ccte_pkg::cmd_t cmd;
	ccte_pkg::sts_t sts;

	ccte_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.kind   (req.kind),
		.sts    (sts),
		.busy   (busy),
		.cmd    (cmd)
	);

	ccte_dpath #(
		.SLOTS (SLOTS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.sts       (sts),
		.done      (done),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire

[src/ccte_dpath.sv]
`default_nettype none

`include "credential_cache_ttl_evict_assert.svh"

module ccte_dpath #(
	parameter int SLOTS = 128
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire ccte_pkg::req_t                 req,
	input  wire logic                           cfg_we,
	input  wire logic [ccte_pkg::TIME_W-1:0]    cfg_wdata,
	input  wire ccte_pkg::cmd_t                 cmd,
	output ccte_pkg::sts_t                      sts,
	output logic                                done,
	output ccte_pkg::rsp_t                      rsp
);

	localparam int IW = $clog2(SLOTS);
	localparam int CW = $clog2(SLOTS + 1);
	localparam int XW = (IW > ccte_pkg::SLOT_W) ? IW : ccte_pkg::SLOT_W;
	localparam int DW = ccte_pkg::DIG_W;
	localparam int TW = ccte_pkg::TIME_W;
	localparam int EW = 2 * DW + TW;

	// entry: {digest_high, digest_low, expiry}
	logic [EW-1:0] mem [SLOTS];

	ccte_pkg::req_t req_q;
	logic [TW-1:0]  lifetime_q;
	logic [CW-1:0]  idx_q;
	logic [CW-1:0]  fill_q;
	logic [EW-1:0]  rd_s1;
	logic [IW-1:0]  rd_idx_s1;
	logic           rd_vld_s1;
	logic [TW-1:0]  best_exp_q;
	logic [IW-1:0]  best_idx_q;
	logic           done_q;
	ccte_pkg::rsp_t rsp_q;

	logic [DW-1:0]  rd_hi;
	logic [DW-1:0]  rd_lo;
	logic [TW-1:0]  rd_exp;
	logic           full;
	logic           match;
	logic [XW-1:0]  clr_ext;
	logic [IW-1:0]  clr_addr;
	logic           clr_ok;
	logic [IW-1:0]  ins_addr;
	logic [TW:0]    exp_sum;
	logic [TW-1:0]  exp_new;
	logic           wr_en;
	logic [IW-1:0]  wr_addr;
	logic [EW-1:0]  wr_data;
	logic [XW-1:0]  hit_ext;
	logic [XW-1:0]  ins_ext;

	assign rd_hi  = rd_s1[EW-1 -: DW];
	assign rd_lo  = rd_s1[TW +: DW];
	assign rd_exp = rd_s1[TW-1:0];

	assign full  = (fill_q == CW'(SLOTS));
	assign match = rd_vld_s1 && (rd_hi == req_q.digest_high) && (rd_lo == req_q.digest_low);

	assign clr_ext  = XW'(req_q.clear_slot);
	assign clr_addr = clr_ext[IW-1:0];
	assign clr_ok   = (32'(req_q.clear_slot) < 32'(SLOTS));

	assign ins_addr = full ? best_idx_q : fill_q[IW-1:0];

	assign exp_sum = {1'b0, req_q.now_seconds} + {1'b0, lifetime_q};
	assign exp_new = exp_sum[TW] ? {TW{1'b1}} : exp_sum[TW-1:0];

	assign wr_en   = cmd.wr_ins || (cmd.wr_clr && clr_ok);
	assign wr_addr = cmd.wr_ins ? ins_addr : clr_addr;
	assign wr_data = cmd.wr_ins ? {req_q.digest_high, req_q.digest_low, exp_new} : '0;

	assign hit_ext = XW'(rd_idx_s1);
	assign ins_ext = XW'(ins_addr);

	assign sts.match = match;
	assign sts.more  = (idx_q < fill_q);
	assign sts.pend  = rd_vld_s1;
	assign sts.full  = full;

	assign done = done_q;
	assign rsp  = rsp_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.issue) begin
			rd_s1     <= mem[idx_q[IW-1:0]];
			rd_idx_s1 <= idx_q[IW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req;
		end
		// strict compare keeps the lowest index on ties
		if (cmd.load || cmd.scan_rst) begin
			best_exp_q <= {TW{1'b1}};
			best_idx_q <= '0;
		end else if (cmd.track && rd_vld_s1 && (rd_exp < best_exp_q)) begin
			best_exp_q <= rd_exp;
			best_idx_q <= rd_idx_s1;
		end
		if (cmd.res_hit) begin
			rsp_q.status     <= (rd_exp < req_q.now_seconds) ?
				ccte_pkg::ST_HIT_EXPIRED : ccte_pkg::ST_HIT_VALID;
			rsp_q.slot_index <= hit_ext[ccte_pkg::SLOT_W-1:0];
		end else if (cmd.res_ins) begin
			rsp_q.status     <= ccte_pkg::ST_MISS_INSERTED;
			rsp_q.slot_index <= ins_ext[ccte_pkg::SLOT_W-1:0];
		end else if (cmd.res_clr) begin
			rsp_q.status     <= ccte_pkg::ST_CLEARED;
			rsp_q.slot_index <= req_q.clear_slot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lifetime_q <= ccte_pkg::DEFAULT_LIFETIME;
			idx_q      <= '0;
			fill_q     <= '0;
			rd_vld_s1  <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				lifetime_q <= cfg_wdata;
			end
			if (cmd.load || cmd.scan_rst) begin
				idx_q <= '0;
			end else if (cmd.issue) begin
				idx_q <= idx_q + CW'(1);
			end
			if (cmd.wr_ins && !full) begin
				fill_q <= fill_q + CW'(1);
			end
			rd_vld_s1 <= cmd.issue;
			done_q    <= cmd.res_hit || cmd.res_ins || cmd.res_clr;
		end
	end

	`CCTE_ASSERT(a_read_in_fill, cmd.issue |-> (idx_q < fill_q), "scan read past the filled slots")
	`CCTE_ASSERT(a_fill_bound, fill_q <= CW'(SLOTS), "fill count above capacity")
	`CCTE_ASSERT(a_one_result, $onehot0({cmd.res_hit, cmd.res_ins, cmd.res_clr}), "two results at once")
	`CCTE_ASSERT(a_done_gap, done_q |=> !done_q, "result word on two cycles in a row")

endmodule

`default_nettype wire

[src/ccte_ctrl.sv]
`default_nettype none

module ccte_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire logic            kind,
	input  wire ccte_pkg::sts_t  sts,
	output logic                 busy,
	output ccte_pkg::cmd_t       cmd
);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_CLEAR = 2'd1;
	localparam logic [1:0] S_MSCAN = 2'd2;
	localparam logic [1:0] S_ESCAN = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_nxt;

	assign busy = (state_q != S_IDLE);

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load  = 1'b1;
					state_nxt = (kind == ccte_pkg::KIND_CLEAR) ? S_CLEAR : S_MSCAN;
				end
			end
			S_CLEAR: begin
				cmd.wr_clr = 1'b1;
				cmd.res_clr = 1'b1;
				state_nxt = S_IDLE;
			end
			S_MSCAN: begin
				cmd.issue = sts.more;
				if (sts.match) begin
					cmd.res_hit = 1'b1;
					state_nxt = S_IDLE;
				end else if (!sts.more && !sts.pend) begin
					if (sts.full) begin
						cmd.issue    = 1'b0;
						cmd.scan_rst = 1'b1;
						state_nxt    = S_ESCAN;
					end else begin
						cmd.wr_ins  = 1'b1;
						cmd.res_ins = 1'b1;
						state_nxt   = S_IDLE;
					end
				end
			end
			S_ESCAN: begin
				// full cache: fill count equals capacity, so the scan covers all slots
				cmd.track = 1'b1;
				cmd.issue = sts.more;
				if (!sts.more && !sts.pend) begin
					cmd.wr_ins  = 1'b1;
					cmd.res_ins = 1'b1;
					state_nxt   = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

`default_nettype wire
